### hw/rtl/rrcc_pkg.sv
// Shared types, constants and the coverage scaling function for the
// rounded rectangle corner coverage pipeline. No dependencies.
package rrcc_pkg;

    // Default coordinate width (rectangle size in pixels fits in this many bits)
    localparam int COORD_BITS_DEF = 12;

    // Subsample grid: 4x4 samples per pixel
    localparam int SUB_N     = 4;
    localparam int SUB_COUNT = SUB_N * SUB_N;
    localparam int HIT_W     = 5;

    // Full coverage value
    localparam logic [7:0] FULL_COV = 8'd255;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_RADIUS = 2'd2;

    // Per-item classification that travels with the data
    typedef struct packed {
        logic empty;  // pixel lies outside the rectangle
        logic full;   // pixel lies outside the corner squares; empty takes priority
    } flag_t;

    // Scale a hit count 0..16 to 0..255 with rounding: (h*255+8)/16
    function automatic logic [7:0] cov_scale(input logic [HIT_W-1:0] hits);
        logic [12:0] prod;
        prod = {hits, 8'd0} - {8'd0, hits} + 13'd8;
        return prod[11:4];
    endfunction

endpackage

### hw/rtl/rrcc_geom.sv
// Geometry stages: inside test, radius clamp, mirroring into the top-left
// corner square and corner classification. Depends on rrcc_pkg.
module rrcc_geom
    import rrcc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS:0]   in_x,
    input  logic signed [COORD_BITS:0]   in_y,
    input  logic [COORD_BITS-1:0]        rect_width,
    input  logic [COORD_BITS-1:0]        rect_height,
    input  logic [COORD_BITS-2:0]        corner_radius,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [COORD_BITS-1:0]        out_xm,
    output logic [COORD_BITS-1:0]        out_ym,
    output logic [COORD_BITS-2:0]        out_r,
    output flag_t                        out_flags
);

    localparam int CB = COORD_BITS;

    logic          s1_valid_reg, s2_valid_reg;
    logic          s1_adv, s2_adv;
    logic [CB-1:0] s1_x_reg, s1_y_reg;
    logic [CB-2:0] s1_r_reg;
    logic          s1_empty_reg;
    logic          s1_empty_next;
    logic [CB-2:0] s1_r_next;
    logic [CB-2:0] half_w, half_h;
    logic [CB-1:0] s2_xm_reg, s2_ym_reg;
    logic [CB-2:0] s2_r_reg;
    flag_t         s2_flags_reg;
    logic [CB-1:0] w_minus_r, h_minus_r, r_ext;
    logic [CB-1:0] xm_next, ym_next;
    flag_t         s2_flags_next;

    // Stall control: a stage moves when its slot is free or its item leaves
    assign s2_adv   = !s2_valid_reg || out_ready;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign in_ready = s1_adv;

    // Stage 1: inside test and radius clamp
    always_comb begin
        half_w = rect_width[CB-1:1];
        half_h = rect_height[CB-1:1];
        s1_empty_next = in_x[CB] || in_y[CB] ||
                        (in_x[CB-1:0] >= rect_width) || (in_y[CB-1:0] >= rect_height);
        s1_r_next = corner_radius;
        if (s1_r_next > half_w) begin
            s1_r_next = half_w;
        end
        if (s1_r_next > half_h) begin
            s1_r_next = half_h;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            s1_x_reg     <= in_x[CB-1:0];
            s1_y_reg     <= in_y[CB-1:0];
            s1_r_reg     <= s1_r_next;
            s1_empty_reg <= s1_empty_next;
        end
    end

    // Stage 2: mirror into the top-left corner and classify
    always_comb begin
        r_ext     = {1'b0, s1_r_reg};
        w_minus_r = rect_width - r_ext;
        h_minus_r = rect_height - r_ext;
        xm_next   = (s1_x_reg >= w_minus_r) ? (rect_width - CB'(1) - s1_x_reg) : s1_x_reg;
        ym_next   = (s1_y_reg >= h_minus_r) ? (rect_height - CB'(1) - s1_y_reg) : s1_y_reg;
        s2_flags_next.empty = s1_empty_reg;
        s2_flags_next.full  = !((xm_next < r_ext) && (ym_next < r_ext));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_adv) begin
            s2_xm_reg    <= xm_next;
            s2_ym_reg    <= ym_next;
            s2_r_reg     <= s1_r_reg;
            s2_flags_reg <= s2_flags_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_xm    = s2_xm_reg;
    assign out_ym    = s2_ym_reg;
    assign out_r     = s2_r_reg;
    assign out_flags = s2_flags_reg;

endmodule

### hw/rtl/rrcc_sample.sv
// Subsample stages: offsets from the circle center, their squares, and the
// 16 in-circle tests that give the hit mask. Depends on rrcc_pkg.
module rrcc_sample
    import rrcc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_BITS-1:0] in_xm,
    input  logic [COORD_BITS-1:0] in_ym,
    input  logic [COORD_BITS-2:0] in_r,
    input  flag_t                 in_flags,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [SUB_COUNT-1:0]  out_hits,
    output flag_t                 out_flags
);

    localparam int CB   = COORD_BITS;
    localparam int SQ_W = 2 * CB + 3;

    logic                 s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic                 s3_adv, s4_adv, s5_adv;

    logic [CB-1:0]        dxw, dyw;
    logic [CB-2:0]        dxd, dyd;
    logic signed [CB+1:0] dx_next [SUB_N];
    logic signed [CB+1:0] dy_next [SUB_N];
    logic signed [CB+1:0] dx_reg  [SUB_N];
    logic signed [CB+1:0] dy_reg  [SUB_N];
    logic [CB:0]          c_reg;
    flag_t                s3_flags_reg;

    logic signed [2*CB+3:0] px [SUB_N];
    logic signed [2*CB+3:0] py [SUB_N];
    logic [SQ_W-1:0]      sqx_next [SUB_N];
    logic [SQ_W-1:0]      sqy_next [SUB_N];
    logic [SQ_W-1:0]      sqx_reg  [SUB_N];
    logic [SQ_W-1:0]      sqy_reg  [SUB_N];
    logic [2*CB+1:0]      rr_prod;
    logic [SQ_W-1:0]      rr_reg;
    flag_t                s4_flags_reg;

    logic [SQ_W:0]        sq_sum;
    logic [SUB_COUNT-1:0] hits_next;
    logic [SUB_COUNT-1:0] hits_reg;
    flag_t                s5_flags_reg;

    // Stall control
    assign s5_adv   = !s5_valid_reg || out_ready;
    assign s4_adv   = !s4_valid_reg || s5_adv;
    assign s3_adv   = !s3_valid_reg || s4_adv;
    assign in_ready = s3_adv;

    // Stage 3: subsample offsets dx = 4(r-x) - 2 - sx
    always_comb begin
        dxw = {1'b0, in_r} - in_xm;
        dyw = {1'b0, in_r} - in_ym;
        dxd = dxw[CB-2:0];
        dyd = dyw[CB-2:0];
        for (int k = 0; k < SUB_N; k++) begin
            dx_next[k] = $signed({1'b0, dxd, 2'b00}) - $signed((CB+2)'(2 + k));
            dy_next[k] = $signed({1'b0, dyd, 2'b00}) - $signed((CB+2)'(2 + k));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (s3_adv) begin
            s3_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_adv) begin
            dx_reg       <= dx_next;
            dy_reg       <= dy_next;
            c_reg        <= {in_r, 2'b00} - (CB+1)'(2);
            s3_flags_reg <= in_flags;
        end
    end

    // Stage 4: squares of the offsets and of the radius
    always_comb begin
        for (int k = 0; k < SUB_N; k++) begin
            px[k]       = dx_reg[k] * dx_reg[k];
            py[k]       = dy_reg[k] * dy_reg[k];
            sqx_next[k] = px[k][SQ_W-1:0];
            sqy_next[k] = py[k][SQ_W-1:0];
        end
        rr_prod = c_reg * c_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (s4_adv) begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s4_adv) begin
            sqx_reg      <= sqx_next;
            sqy_reg      <= sqy_next;
            rr_reg       <= {1'b0, rr_prod};
            s4_flags_reg <= s3_flags_reg;
        end
    end

    // Stage 5: in-circle test for each of the 16 subsamples
    always_comb begin
        sq_sum = '0;
        for (int sy = 0; sy < SUB_N; sy++) begin
            for (int sx = 0; sx < SUB_N; sx++) begin
                sq_sum = {1'b0, sqx_reg[sx]} + {1'b0, sqy_reg[sy]};
                hits_next[sy*SUB_N + sx] = (sq_sum <= {1'b0, rr_reg});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_valid_reg <= 1'b0;
        end else if (s5_adv) begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s5_adv) begin
            hits_reg     <= hits_next;
            s5_flags_reg <= s4_flags_reg;
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_hits  = hits_reg;
    assign out_flags = s5_flags_reg;

endmodule

### hw/rtl/rrcc_score.sv
// Output stage: count hits, scale to 0..255 and pick the final coverage.
// Holds the output register of the stream. Depends on rrcc_pkg.
module rrcc_score
    import rrcc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [SUB_COUNT-1:0] in_hits,
    input  flag_t                in_flags,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_coverage
);

    logic             valid_reg;
    logic [7:0]       cov_reg;
    logic [7:0]       cov_next;
    logic [HIT_W-1:0] count;
    logic             adv;

    assign adv      = !valid_reg || out_ready;
    assign in_ready = adv;

    // Count hits and select the coverage
    always_comb begin
        count = '0;
        for (int i = 0; i < SUB_COUNT; i++) begin
            count = count + HIT_W'(in_hits[i]);
        end
        if (in_flags.empty) begin
            cov_next = 8'd0;
        end else if (in_flags.full) begin
            cov_next = FULL_COV;
        end else begin
            cov_next = cov_scale(count);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cov_reg <= cov_next;
        end
    end

    assign out_valid    = valid_reg;
    assign out_coverage = cov_reg;

endmodule

### hw/rtl/rounded_rect_corner_coverage.sv
// Top level of the rounded rectangle corner coverage pipeline: stream ports,
// configuration registers and the geometry, sample and score stages.
// Depends on rrcc_pkg, rrcc_geom, rrcc_sample and rrcc_score.
//
// Takes one pixel position relative to the top-left corner of a rounded
// rectangle per item and returns its 4x4 supersampled coverage, 0 to 255.
// The pipeline is six register stages deep (inside test and radius clamp,
// corner mirroring, subsample offsets, squares, circle tests, hit count and
// scale), and one item can be accepted every cycle while the output is not
// stalled. Back-pressure on the output stalls only as far back as there
// are no empty stages. Width, height and radius are written through the cfg
// port (index 0 width, 1 height, 2 radius; other indexes are ignored) and
// must only change while the pipeline is empty.
module rounded_rect_corner_coverage
    import rrcc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [COORD_BITS-1:0]         cfg_data,
    // input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata fields from bit 0: pixel_x, pixel_y, zero padding
    input  logic [((2*COORD_BITS+9)/8)*8-1:0] s_tdata,
    // result items
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata fields from bit 0: coverage
    output logic [7:0]                    m_tdata
);

    localparam int CB = COORD_BITS;

    logic [CB-1:0]        rect_width_reg;
    logic [CB-1:0]        rect_height_reg;
    logic [CB-2:0]        corner_radius_reg;

    logic signed [CB:0]   pixel_x, pixel_y;

    logic                 g_valid, g_ready;
    logic [CB-1:0]        g_xm, g_ym;
    logic [CB-2:0]        g_r;
    flag_t                g_flags;

    logic                 p_valid, p_ready;
    logic [SUB_COUNT-1:0] p_hits;
    flag_t                p_flags;

    // Configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rect_width_reg    <= CB'(1);
            rect_height_reg   <= CB'(1);
            corner_radius_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_RECT_WIDTH:    rect_width_reg    <= cfg_data;
                REG_RECT_HEIGHT:   rect_height_reg   <= cfg_data;
                REG_CORNER_RADIUS: corner_radius_reg <= cfg_data[CB-2:0];
                default: ;
            endcase
        end
    end

    // Unpack the input item
    assign pixel_x = $signed(s_tdata[CB:0]);
    assign pixel_y = $signed(s_tdata[2*CB+1:CB+1]);

    rrcc_geom #(
        .COORD_BITS(COORD_BITS)
    ) u_geom (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_x         (pixel_x),
        .in_y         (pixel_y),
        .rect_width   (rect_width_reg),
        .rect_height  (rect_height_reg),
        .corner_radius(corner_radius_reg),
        .out_valid    (g_valid),
        .out_ready    (g_ready),
        .out_xm       (g_xm),
        .out_ym       (g_ym),
        .out_r        (g_r),
        .out_flags    (g_flags)
    );

    rrcc_sample #(
        .COORD_BITS(COORD_BITS)
    ) u_sample (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (g_valid),
        .in_ready (g_ready),
        .in_xm    (g_xm),
        .in_ym    (g_ym),
        .in_r     (g_r),
        .in_flags (g_flags),
        .out_valid(p_valid),
        .out_ready(p_ready),
        .out_hits (p_hits),
        .out_flags(p_flags)
    );

    rrcc_score u_score (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (p_valid),
        .in_ready    (p_ready),
        .in_hits     (p_hits),
        .in_flags    (p_flags),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_coverage(m_tdata)
    );

endmodule
